FILE: src/vlna_pkg.sv
package vlna_pkg;

    // one input transaction
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       dir_start;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic       entry_done;
        logic       long_name_ready;
        logic       end_seen;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    // directory entry codes
    localparam logic [7:0] ORD_END      = 8'h00;
    localparam logic [7:0] ORD_DELETED  = 8'hE5;
    localparam logic [7:0] ATTR_LFN     = 8'h0F;
    localparam logic [7:0] ATTR_LABEL   = 8'h08;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam int         ORD_LAST_BIT = 6;
    localparam int         UNITS_PER_SLOT = 13;
    localparam logic [3:0] LAST_UNIT    = 4'd12;
    localparam logic [4:0] LAST_BYTE    = 5'd31;
    localparam logic [4:0] SHORT_LEN    = 5'd11;

    // utf-16 and code point constants
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [15:0] UNIT_NUL    = 16'h0000;
    localparam logic [15:0] UNIT_FILL   = 16'hFFFF;
    localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP     = 21'h010000;
    localparam logic [20:0] CP_NUL      = 21'h000000;
    localparam logic [20:0] CP_SLASH    = 21'h00002F;
    localparam logic [20:0] CP_BSLASH   = 21'h00005C;
    localparam logic [20:0] CP_USCORE   = 21'h00005F;

    // name store read address source
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_UNIT,
        RD_PAIR,
        RD_NEXT
    } rd_src_t;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    push;
        logic    classify;
        logic    copy;
        logic    check;
        logic    pull_w;
        logic    pull_lo;
        logic    pull_out;
        logic    pull_end;
        logic    emit;
        rd_src_t rd_src;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic func;
        logic push_full;
        logic slot_store;
        logic reg_ok;
        logic copy_last;
        logic pending;
        logic final_byte;
        logic next_in_range;
        logic out_free;
    } status_t;

    // byte offset of each name unit inside a long-name slot
    function automatic logic [4:0] unit_offset(input logic [3:0] k);
        logic [4:0] o;
        case (k)
            4'd0:    o = 5'd1;
            4'd1:    o = 5'd3;
            4'd2:    o = 5'd5;
            4'd3:    o = 5'd7;
            4'd4:    o = 5'd9;
            4'd5:    o = 5'd14;
            4'd6:    o = 5'd16;
            4'd7:    o = 5'd18;
            4'd8:    o = 5'd20;
            4'd9:    o = 5'd22;
            4'd10:   o = 5'd24;
            4'd11:   o = 5'd28;
            4'd12:   o = 5'd30;
            default: o = 5'd1;
        endcase
        return o;
    endfunction

    // utf-8 sequence length
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
            n = 3'd1;
        else if (cp < 21'h800)
            n = 3'd2;
        else if (cp < 21'h10000)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

    // one byte of the utf-8 sequence
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                             input logic [1:0] idx);
        logic [7:0] lead;
        logic [1:0] rem;
        logic [5:0] grp;
        logic [7:0] b;
        case (n)
            3'd1:    lead = cp[7:0];
            3'd2:    lead = {3'b110, cp[10:6]};
            3'd3:    lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        rem = 2'(n - 3'd1 - {1'b0, idx});
        case (rem)
            2'd0:    grp = cp[5:0];
            2'd1:    grp = cp[11:6];
            2'd2:    grp = cp[17:12];
            default: grp = {3'b000, cp[20:18]};
        endcase
        b = (idx == 2'd0) ? lead : {2'b10, grp};
        return b;
    endfunction

endpackage

FILE: src/vlna_stream_if.sv
interface vlna_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/vfat_long_name_assembler.sv
// channel  | direction | payload
// item     | in        | func, data_byte, dir_start
// result   | out       | entry_done, long_name_ready, end_seen, out_valid, out_byte, out_last
//
// one transaction at a time; ready is high only while the controller is idle
// directory byte: push, and on the entry's last byte classify, then copy a long-name
// slot's 13 units into the unit store or probe the first unit of a regular entry
// name pull: with a name pending, unit read, pair read, byte out, maybe an end probe
// a finished result waits in the output register; the next item is taken meanwhile
// reset clears all control state; the entry buffer and unit store are not cleared
module vfat_long_name_assembler #(
    parameter int MAX_SLOTS = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    vlna_stream_if.sink   item,
    vlna_stream_if.source result
);
    import vlna_pkg::*;

    cmd_t    cmd;
    status_t st;

    vlna_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    vlna_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .st     (st)
    );
endmodule

FILE: src/vlna_ram.sv
module vlna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 260
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/vlna_ctrl.sv
module vlna_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  vlna_pkg::status_t st,
    output vlna_pkg::cmd_t    cmd
);
    import vlna_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_PUSH     = 12'b0000_0000_0010,
        S_CLASS    = 12'b0000_0000_0100,
        S_COPY     = 12'b0000_0000_1000,
        S_CHECK    = 12'b0000_0001_0000,
        S_CHECK_W  = 12'b0000_0010_0000,
        S_PULL     = 12'b0000_0100_0000,
        S_PULL_W   = 12'b0000_1000_0000,
        S_PULL_LO  = 12'b0001_0000_0000,
        S_PULL_OUT = 12'b0010_0000_0000,
        S_PULL_END = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // sequencing of one transaction
    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = RD_ZERO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    state_next = st.func ? S_PULL : S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = st.push_full ? S_CLASS : S_EMIT;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                if (st.slot_store)
                    state_next = S_COPY;
                else if (st.reg_ok)
                    state_next = S_CHECK;
                else
                    state_next = S_EMIT;
            end
            S_COPY:
            begin
                cmd.copy = 1'b1;
                if (st.copy_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_CHECK:
            begin
                cmd.rd_src = RD_ZERO;
                state_next = S_CHECK_W;
            end
            S_CHECK_W:
            begin
                cmd.check  = 1'b1;
                state_next = S_EMIT;
            end
            S_PULL:
            begin
                cmd.rd_src = RD_UNIT;
                state_next = st.pending ? S_PULL_W : S_EMIT;
            end
            S_PULL_W:
            begin
                cmd.pull_w = 1'b1;
                cmd.rd_src = RD_PAIR;
                state_next = S_PULL_LO;
            end
            S_PULL_LO:
            begin
                cmd.pull_lo = 1'b1;
                state_next  = S_PULL_OUT;
            end
            S_PULL_OUT:
            begin
                cmd.pull_out = 1'b1;
                cmd.rd_src   = RD_NEXT;
                state_next   = (st.final_byte && st.next_in_range) ? S_PULL_END : S_EMIT;
            end
            S_PULL_END:
            begin
                cmd.pull_end = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: src/vlna_datapath.sv
module vlna_datapath #(
    parameter int MAX_SLOTS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    vlna_stream_if.sink       item,
    vlna_stream_if.source     result,
    input  vlna_pkg::cmd_t    cmd,
    output vlna_pkg::status_t st
);
    import vlna_pkg::*;

    localparam int UNIT_DEPTH = MAX_SLOTS * UNITS_PER_SLOT;
    localparam int AW         = $clog2(UNIT_DEPTH);
    localparam int UW         = $clog2(UNIT_DEPTH + 2);

    item_t                item_reg;
    logic [7:0]           ebuf_reg [32];
    logic [4:0]           pos_reg, pos_next;
    logic [7:0]           sum_reg, sum_next;
    logic [MAX_SLOTS-1:0] present_reg, present_next;
    logic [4:0]           count_reg, count_next;
    logic [7:0]           chk_reg, chk_next;
    logic                 active_reg, active_next;
    logic                 ended_reg, ended_next;
    logic                 pending_reg, pending_next;
    logic [UW-1:0]        runit_reg, runit_next;
    logic [UW-1:0]        limit_reg, limit_next;
    logic [1:0]           rbyte_reg, rbyte_next;
    logic [3:0]           copy_k_reg, copy_k_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [15:0]          w_reg;
    logic [20:0]          cp_reg, cp_next;
    logic                 used2_reg, used2_next;
    result_t              work_reg, work_next;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic                 accept;
    logic [4:0]           pos_eff;
    logic                 ended_eff;
    logic                 ebuf_we;
    logic [7:0]           b0, b1, b11, b13;
    logic [4:0]           slot;
    logic                 ord_last;
    logic                 is_end, is_del, is_lfn, is_label, is_dot;
    logic                 slot_valid, store_ok, chain_full, reg_ok;
    logic                 eff_active;
    logic [4:0]           eff_count;
    logic [7:0]           eff_chk;
    logic [MAX_SLOTS-1:0] slot_bit;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [15:0]          ram_wdata, ram_rdata;
    logic [4:0]           off;
    logic [UW-1:0]        runit_p1, runit_adv;
    logic                 pair_ok;
    logic [2:0]           cp_len;
    logic [1:0]           rb_eff;
    logic                 final_byte;
    logic                 unit_stop;

    assign accept      = item.valid && cmd.in_ready;
    assign item.ready  = cmd.in_ready;

    // push view after a possible directory start
    assign pos_eff   = item_reg.dir_start ? 5'd0 : pos_reg;
    assign ended_eff = !item_reg.dir_start && ended_reg;
    assign ebuf_we   = cmd.push && !ended_eff;

    // entry classification
    assign b0       = ebuf_reg[0];
    assign b1       = ebuf_reg[1];
    assign b11      = ebuf_reg[11];
    assign b13      = ebuf_reg[13];
    assign slot     = b0[4:0];
    assign ord_last = b0[ORD_LAST_BIT];
    assign is_end   = (b0 == ORD_END);
    assign is_del   = (b0 == ORD_DELETED);
    assign is_lfn   = (b11 == ATTR_LFN);
    assign is_label = ((b11 & ATTR_LABEL) != 8'h00);
    assign is_dot   = (b0 == CHAR_DOT) && ((b1 == CHAR_SPACE) || (b1 == CHAR_DOT));

    // long-name slot check
    assign slot_valid = (slot != 5'd0) && (slot <= 5'(MAX_SLOTS));
    assign eff_active = ord_last || active_reg;
    assign eff_count  = ord_last ? slot : count_reg;
    assign eff_chk    = ord_last ? b13 : chk_reg;
    assign store_ok   = slot_valid && eff_active && (slot <= eff_count) && (b13 == eff_chk);
    assign slot_bit   = {{(MAX_SLOTS-1){1'b0}}, 1'b1} << (slot - 5'd1);

    // every slot of the chain seen
    always_comb
    begin
        chain_full = 1'b1;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            if ((5'(k) < count_reg) && !present_reg[k])
                chain_full = 1'b0;
        end
    end

    assign reg_ok = active_reg && (count_reg != 5'd0) && (chk_reg == sum_reg) && chain_full;

    // name store ports
    assign off       = unit_offset(copy_k_reg);
    assign ram_we    = cmd.copy;
    assign ram_waddr = base_reg + AW'(copy_k_reg);
    assign ram_wdata = {ebuf_reg[off + 5'd1], ebuf_reg[off]};
    assign runit_p1  = runit_reg + UW'(1);
    assign runit_adv = runit_reg + (used2_reg ? UW'(2) : UW'(1));

    always_comb
    begin
        case (cmd.rd_src)
            RD_ZERO: ram_raddr = '0;
            RD_UNIT: ram_raddr = AW'(runit_reg);
            RD_PAIR: ram_raddr = AW'(runit_p1);
            RD_NEXT: ram_raddr = AW'(runit_adv);
            default: ram_raddr = '0;
        endcase
    end

    vlna_ram #(
        .WIDTH (16),
        .DEPTH (UNIT_DEPTH)
    ) u_units (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pull decode
    assign pair_ok    = runit_p1 < limit_reg;
    assign cp_len     = utf8_len(cp_reg);
    assign rb_eff     = ({1'b0, rbyte_reg} >= cp_len) ? 2'd0 : rbyte_reg;
    assign final_byte = ({1'b0, rb_eff} + 3'd1) >= cp_len;
    assign unit_stop  = (ram_rdata == UNIT_NUL) || (ram_rdata == UNIT_FILL);

    // next state of the datapath
    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        present_next = present_reg;
        count_next   = count_reg;
        chk_next     = chk_reg;
        active_next  = active_reg;
        ended_next   = ended_reg;
        pending_next = pending_reg;
        runit_next   = runit_reg;
        limit_next   = limit_reg;
        rbyte_next   = rbyte_reg;
        copy_k_next  = copy_k_reg;
        base_next    = base_reg;
        cp_next      = cp_reg;
        used2_next   = used2_reg;
        work_next    = work_reg;

        if (accept)
        begin
            work_next = '0;
        end

        // directory byte
        if (cmd.push)
        begin
            if (item_reg.dir_start)
            begin
                present_next = '0;
                count_next   = 5'd0;
                chk_next     = 8'h00;
                active_next  = 1'b0;
                ended_next   = 1'b0;
                pending_next = 1'b0;
                pos_next     = 5'd0;
            end
            if (!ended_eff)
            begin
                pos_next = pos_eff + 5'd1;
                if (pos_eff == 5'd0)
                    sum_next = item_reg.data_byte;
                else if (pos_eff < SHORT_LEN)
                    sum_next = {sum_reg[0], sum_reg[7:1]} + item_reg.data_byte;
            end
        end

        // end of entry
        if (cmd.classify)
        begin
            present_next = '0;
            count_next   = 5'd0;
            chk_next     = 8'h00;
            active_next  = 1'b0;
            if (is_end)
            begin
                ended_next         = 1'b1;
                work_next.end_seen = 1'b1;
            end
            else if (is_del)
            begin
                ended_next = ended_reg;
            end
            else if (is_lfn)
            begin
                if (store_ok)
                begin
                    active_next  = 1'b1;
                    count_next   = eff_count;
                    chk_next     = eff_chk;
                    present_next = (ord_last ? '0 : present_reg) | slot_bit;
                    pending_next = 1'b0;
                    base_next    = AW'((slot - 5'd1) * UNITS_PER_SLOT);
                    copy_k_next  = 4'd0;
                end
            end
            else if (!is_label && !is_dot)
            begin
                work_next.entry_done = 1'b1;
                pending_next         = 1'b0;
                if (reg_ok)
                    limit_next = UW'(count_reg * UNITS_PER_SLOT);
            end
        end

        if (cmd.copy)
        begin
            copy_k_next = copy_k_reg + 4'd1;
        end

        // first unit of a new name
        if (cmd.check && !unit_stop)
        begin
            pending_next              = 1'b1;
            runit_next                = '0;
            rbyte_next                = 2'd0;
            work_next.long_name_ready = 1'b1;
        end

        // code point from one or two units
        if (cmd.pull_lo)
        begin
            cp_next    = {5'b00000, w_reg};
            used2_next = 1'b0;
            if ((w_reg >= HI_SURR_MIN) && (w_reg <= HI_SURR_MAX))
            begin
                cp_next = CP_REPLACE;
                if (pair_ok && (ram_rdata >= LO_SURR_MIN) && (ram_rdata <= LO_SURR_MAX))
                begin
                    cp_next    = CP_SUPP + {1'b0, w_reg[9:0], ram_rdata[9:0]};
                    used2_next = 1'b1;
                end
            end
            else if ((w_reg >= LO_SURR_MIN) && (w_reg <= LO_SURR_MAX))
            begin
                cp_next = CP_REPLACE;
            end
            if ((cp_next == CP_SLASH) || (cp_next == CP_BSLASH) || (cp_next == CP_NUL))
                cp_next = CP_USCORE;
        end

        // one utf-8 byte out
        if (cmd.pull_out)
        begin
            work_next.out_valid = 1'b1;
            work_next.out_byte  = utf8_byte(cp_reg, cp_len, rb_eff);
            if (final_byte)
            begin
                rbyte_next = 2'd0;
                runit_next = runit_adv;
                if (runit_adv >= limit_reg)
                begin
                    work_next.out_last = 1'b1;
                    pending_next       = 1'b0;
                end
            end
            else
            begin
                rbyte_next = rb_eff + 2'd1;
            end
        end

        if (cmd.pull_end && unit_stop)
        begin
            work_next.out_last = 1'b1;
            pending_next       = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 5'd0;
            present_reg   <= '0;
            count_reg     <= 5'd0;
            chk_reg       <= 8'h00;
            active_reg    <= 1'b0;
            ended_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            runit_reg     <= '0;
            limit_reg     <= '0;
            rbyte_reg     <= 2'd0;
            copy_k_reg    <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            chk_reg     <= chk_next;
            active_reg  <= active_next;
            ended_reg   <= ended_next;
            pending_reg <= pending_next;
            runit_reg   <= runit_next;
            limit_reg   <= limit_next;
            rbyte_reg   <= rbyte_next;
            copy_k_reg  <= copy_k_next;
            if (cmd.emit && st.out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item.data;
        if (ebuf_we)
            ebuf_reg[pos_eff] <= item_reg.data_byte;
        if (cmd.pull_w)
            w_reg <= ram_rdata;
        if (cmd.emit && st.out_free)
            out_reg <= work_reg;
        sum_reg   <= sum_next;
        base_reg  <= base_next;
        cp_reg    <= cp_next;
        used2_reg <= used2_next;
        work_reg  <= work_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // status to the controller
    always_comb
    begin
        st               = '0;
        st.in_valid      = item.valid;
        st.func          = item.data.func;
        st.push_full     = !ended_eff && (pos_eff == LAST_BYTE);
        st.slot_store    = !is_end && !is_del && is_lfn && store_ok;
        st.reg_ok        = !is_end && !is_del && !is_lfn && !is_label && !is_dot && reg_ok;
        st.copy_last     = (copy_k_reg == LAST_UNIT);
        st.pending       = pending_reg;
        st.final_byte    = final_byte;
        st.next_in_range = runit_adv < limit_reg;
        st.out_free      = !out_valid_reg || result.ready;
    end
endmodule

FILE: src/vlna_checker.sv
module vlna_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input vlna_pkg::result_t result_data
);
    import vlna_pkg::*;

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // stalled result payload unchanged
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    // one transaction in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

    // push and pull result fields never mix, and each set of flags is self-consistent
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_data.out_valid &&
                           (result_data.entry_done || result_data.long_name_ready ||
                            result_data.end_seen)) &&
                         (!result_data.long_name_ready || result_data.entry_done) &&
                         (!result_data.out_last || result_data.out_valid) &&
                         !(result_data.entry_done && result_data.end_seen))
        else $error("inconsistent result fields");
endmodule

bind vfat_long_name_assembler vlna_checker u_vlna_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

FILE: tb/tb_vfat_long_name_assembler.sv
`timescale 1ns / 100ps

module tb_vfat_long_name_assembler;
    import vlna_pkg::*;

    localparam int NAME_SLOTS = 20;
    localparam int UNIT_DEPTH = NAME_SLOTS * 13;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 60;

    // one queued transaction, optionally held back until all results are in
    typedef struct {
        item_t it;
        bit    drain;
    } pending_t;

    logic clk;
    logic rst_n;

    vlna_stream_if #(.T(item_t))   item_ch ();
    vlna_stream_if #(.T(result_t)) result_ch ();

    vfat_long_name_assembler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    pending_t stim_q[$];
    result_t  expected_q[$];
    int       errors;
    int       accepted;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;

    // predictor state
    logic [7:0]  ent_buf[32];
    logic [4:0]  ent_pos;
    logic [15:0] unit_store[UNIT_DEPTH];
    logic [19:0] slots_seen;
    int          chain_len;
    logic [7:0]  chain_sum;
    bit          chain_on;
    bit          dir_ended;
    bit          name_ready;
    int          rd_unit;
    int          rd_byte;
    int          name_units;

    int slot_ofs[13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void chain_reset();
        slots_seen = '0;
        chain_len = 0;
        chain_sum = '0;
        chain_on = 1'b0;
    endfunction

    function automatic logic [7:0] short_checksum(logic [7:0] b[32]);
        logic [7:0] s;
        s = '0;
        for (int k = 0; k < 11; k++)
            s = {s[0], s[7:1]} + b[k];
        return s;
    endfunction

    function automatic bit unit_is_end(int i);
        if (i >= name_units || i >= UNIT_DEPTH)
            return 1'b1;
        return unit_store[i] == UNIT_NUL || unit_store[i] == UNIT_FILL;
    endfunction

    // utf-16 to code point, with replacement of bad surrogates, slashes and NUL
    function automatic logic [20:0] code_point_at(int i, output int used);
        logic [20:0] cp;
        logic [15:0] w;
        logic [15:0] lo;
        w = unit_store[i];
        cp = {5'd0, w};
        used = 1;
        if (w >= HI_SURR_MIN && w <= HI_SURR_MAX) begin
            cp = CP_REPLACE;
            if (i + 1 < name_units && i + 1 < UNIT_DEPTH) begin
                lo = unit_store[i + 1];
                if (lo >= LO_SURR_MIN && lo <= LO_SURR_MAX) begin
                    cp = CP_SUPP + ({5'd0, w - HI_SURR_MIN} << 10) + {5'd0, lo - LO_SURR_MIN};
                    used = 2;
                end
            end
        end else if (w >= LO_SURR_MIN && w <= LO_SURR_MAX) begin
            cp = CP_REPLACE;
        end
        if (cp == CP_SLASH || cp == CP_BSLASH || cp == CP_NUL)
            cp = CP_USCORE;
        return cp;
    endfunction

    function automatic int utf8_bytes(logic [20:0] cp, output logic [7:0] b[4]);
        b = '{default: 8'h00};
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            return 3;
        end
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // long-name slot: check ordinal, last flag and checksum, then store units
    function automatic void store_slot();
        int slot;
        int base;
        slot = ent_buf[0] & 8'h1F;
        if (slot == 0 || slot > NAME_SLOTS) begin
            chain_reset();
            return;
        end
        if (ent_buf[0][ORD_LAST_BIT]) begin
            chain_reset();
            chain_on = 1'b1;
            chain_len = slot;
            chain_sum = ent_buf[13];
        end
        if (!chain_on || slot > chain_len || ent_buf[13] != chain_sum) begin
            chain_reset();
            return;
        end
        base = (slot - 1) * 13;
        for (int k = 0; k < 13; k++)
            unit_store[base + k] = {ent_buf[slot_ofs[k] + 1], ent_buf[slot_ofs[k]]};
        slots_seen[slot - 1] = 1'b1;
        name_ready = 1'b0;
    endfunction

    function automatic result_t predict_result(item_t it);
        result_t r;
        logic [7:0] b[4];
        logic [20:0] cp;
        int used;
        int n;
        bit ok;
        r = '0;
        if (it.func) begin
            if (!name_ready)
                return r;
            cp = code_point_at(rd_unit, used);
            n = utf8_bytes(cp, b);
            if (rd_byte >= n)
                rd_byte = 0;
            r.out_valid = 1'b1;
            r.out_byte = b[rd_byte];
            if (rd_byte + 1 >= n) begin
                rd_byte = 0;
                rd_unit = (rd_unit + used) & 511;
                if (unit_is_end(rd_unit)) begin
                    r.out_last = 1'b1;
                    name_ready = 1'b0;
                end
            end else begin
                rd_byte++;
            end
            return r;
        end
        if (it.dir_start) begin
            chain_reset();
            dir_ended = 1'b0;
            name_ready = 1'b0;
            ent_pos = '0;
        end
        if (dir_ended)
            return r;
        ent_buf[ent_pos] = it.data_byte;
        if (ent_pos != LAST_BYTE) begin
            ent_pos++;
            return r;
        end
        ent_pos = '0;
        // classify the completed entry
        if (ent_buf[0] == ORD_END) begin
            dir_ended = 1'b1;
            chain_reset();
            r.end_seen = 1'b1;
        end else if (ent_buf[0] == ORD_DELETED) begin
            chain_reset();
        end else if (ent_buf[11] == ATTR_LFN) begin
            store_slot();
        end else if ((ent_buf[11] & ATTR_LABEL) != 0) begin
            chain_reset();
        end else if (ent_buf[0] == CHAR_DOT &&
                     (ent_buf[1] == CHAR_SPACE || ent_buf[1] == CHAR_DOT)) begin
            chain_reset();
        end else begin
            ok = chain_on && chain_len != 0 && chain_sum == short_checksum(ent_buf);
            for (int k = 0; k < chain_len; k++)
                if (!slots_seen[k])
                    ok = 1'b0;
            r.entry_done = 1'b1;
            name_ready = 1'b0;
            if (ok) begin
                name_units = chain_len * 13;
                if (!unit_is_end(0)) begin
                    name_ready = 1'b1;
                    rd_unit = 0;
                    rd_byte = 0;
                    r.long_name_ready = 1'b1;
                end
            end
            chain_reset();
        end
        return r;
    endfunction

    task automatic report(string what, result_t got, result_t want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // stimulus helpers
    task automatic add_item(bit fn, logic [7:0] d, bit st, bit drain = 1'b0);
        pending_t p;
        p.it.func = fn;
        p.it.data_byte = d;
        p.it.dir_start = st;
        p.drain = drain;
        stim_q.push_back(p);
    endtask

    task automatic add_entry(logic [7:0] e[32], bit st = 1'b0);
        for (int k = 0; k < 32; k++)
            add_item(1'b0, e[k], st && k == 0);
    endtask

    task automatic add_pulls(int n);
        for (int k = 0; k < n; k++)
            add_item(1'b1, 8'($urandom), 1'($urandom));
    endtask

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(16'h20, 16'h7E));
            6:       return $urandom_range(1) ? 16'h002F : 16'h005C;
            7:       return 16'($urandom_range(16'h80, 16'h7FF));
            8:       return 16'($urandom_range(16'h800, 16'hD7FF));
            9, 10:   return 16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
            11, 12:  return 16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
            13:      return 16'($urandom_range(16'hE000, 16'hFFFE));
            14:      return UNIT_NUL;
            15:      return UNIT_FILL;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void rand_short(output logic [7:0] e[32]);
        foreach (e[k])
            e[k] = 8'($urandom);
        e[0] = 8'($urandom_range(8'h41, 8'h5A));
        e[11] = 8'($urandom) & ~ATTR_LABEL;
    endfunction

    // long-name chain plus its short entry and random pulls; fault 0 is a clean chain
    task automatic add_name(int nslots, int fault, bit st = 1'b0);
        logic [7:0] sh[32];
        logic [7:0] e[32];
        logic [7:0] sum;
        logic [15:0] u;
        int skip;
        rand_short(sh);
        sum = short_checksum(sh);
        skip = $urandom_range(1, nslots);
        for (int s = nslots; s >= 1; s--) begin
            if (fault == 2 && s == skip && nslots > 1)
                continue;
            foreach (e[k])
                e[k] = 8'($urandom);
            e[0] = 8'(s) | (s == nslots ? 8'h40 : 8'h00) | ($urandom_range(1) ? 8'h80 : 8'h00);
            if (fault == 3 && s == skip)
                e[0] = (e[0] & 8'hE0) | ($urandom_range(1) ? 8'h00 : 8'($urandom_range(21, 31)));
            if (fault == 4 && s == nslots)
                e[0] = e[0] & ~8'h40;
            e[11] = ATTR_LFN;
            e[13] = (fault == 1 && s == skip) ? sum ^ 8'($urandom_range(1, 255)) : sum;
            for (int k = 0; k < 13; k++) begin
                u = rand_unit();
                e[slot_ofs[k]] = u[7:0];
                e[slot_ofs[k] + 1] = u[15:8];
            end
            add_entry(e, st && s == nslots);
        end
        if (fault == 5)
            sh[3] = sh[3] ^ 8'($urandom_range(1, 255));
        add_entry(sh);
        add_pulls($urandom_range(0, nslots * 13 * 3 + 3));
    endtask

    task automatic add_special(int kind);
        logic [7:0] e[32];
        foreach (e[k])
            e[k] = 8'($urandom);
        case (kind)
            0: e[0] = ORD_DELETED;
            1: begin
                e[0] = 8'($urandom_range(8'h41, 8'h5A));
                e[11] = e[11] | ATTR_LABEL;
            end
            2: begin
                e[0] = CHAR_DOT;
                e[1] = $urandom_range(1) ? CHAR_SPACE : CHAR_DOT;
                e[11] = e[11] & ~ATTR_LABEL;
            end
            default: e[0] = ORD_END;
        endcase
        add_entry(e);
        if (kind == 3) begin
            // ignored bytes, then a fresh directory
            for (int k = 0; k < $urandom_range(1, 40); k++)
                add_item(1'b0, 8'($urandom), 1'b0);
            add_pulls(2);
            foreach (e[k])
                e[k] = 8'($urandom);
            add_entry(e, 1'b1);
        end
    endtask

    // watchdog on forward progress
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // idling phases follow progress through the stimulus
    always_comb begin
        case ((accepted / 120) % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    end

    // driver; a draining transaction also waits out the one being taken now
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            item_ch.data <= '0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(stim_q[0].drain && (expected_q.size() != 0 || item_ch.valid))) begin
                item_ch.valid <= 1'b1;
                item_ch.data <= stim_q[0].it;
                void'(stim_q.pop_front());
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // accepted inputs feed the predictor
    always @(posedge clk) begin
        if (rst_n && item_ch.valid && item_ch.ready) begin
            expected_q.push_back(predict_result(item_ch.data));
            accepted <= accepted + 1;
        end
    end

    // receiver stalls and result check
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= $urandom_range(99) >= recv_stall_pct;
            if (result_ch.valid && result_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transaction", result_ch.data, '0);
                end else begin
                    if (result_ch.data.entry_done != expected_q[0].entry_done)
                        report("entry_done", result_ch.data, expected_q[0]);
                    if (result_ch.data.long_name_ready != expected_q[0].long_name_ready)
                        report("long_name_ready", result_ch.data, expected_q[0]);
                    if (result_ch.data.end_seen != expected_q[0].end_seen)
                        report("end_seen", result_ch.data, expected_q[0]);
                    if (result_ch.data.out_valid != expected_q[0].out_valid)
                        report("out_valid", result_ch.data, expected_q[0]);
                    if (result_ch.data.out_byte != expected_q[0].out_byte)
                        report("out_byte", result_ch.data, expected_q[0]);
                    if (result_ch.data.out_last != expected_q[0].out_last)
                        report("out_last", result_ch.data, expected_q[0]);
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    initial begin
        logic [7:0] e[32];
        errors = 0;
        accepted = 0;
        idle_cycles = 0;
        ent_pos = '0;
        chain_reset();
        dir_ended = 1'b0;
        name_ready = 1'b0;
        rd_unit = 0;
        rd_byte = 0;
        name_units = 0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
        rst_n = 1'b0;

        // directed: pull with nothing pending, clean and faulty names, special entries
        add_pulls(2);
        add_name(1, 0, 1'b1);
        add_pulls(4);
        add_name(1, 1);
        add_name(2, 2);
        for (int k = 0; k < 4; k++)
            add_special(k);
        // restart a directory in the middle of an entry
        for (int k = 0; k < 9; k++)
            add_item(1'b0, 8'($urandom), 1'b0);
        add_name(1, 0, 1'b1);
        add_pulls(3);
        add_item(1'b1, 8'h00, 1'b0, 1'b1);

        // random part
        while (stim_q.size() < 600) begin
            case ($urandom_range(11))
                0, 1, 2, 3, 4: add_name($urandom_range(1, 3), 0);
                5, 6:    add_name($urandom_range(1, 3), $urandom_range(1, 5));
                7: begin
                    foreach (e[k])
                        e[k] = 8'($urandom);
                    add_entry(e, $urandom_range(3) == 0);
                end
                8:       add_special($urandom_range(3));
                9:       add_pulls($urandom_range(1, 6));
                10:      add_item(1'b1, 8'($urandom), 1'b0, 1'b1);
                default: add_name($urandom_range(1, 2), 0, 1'b1);
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_q.size() == 0);
        @(posedge clk);
        while (item_ch.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/vlna_pkg.sv
src/vlna_stream_if.sv
src/vlna_ram.sv
src/vlna_ctrl.sv
src/vlna_datapath.sv
src/vfat_long_name_assembler.sv
src/vlna_checker.sv
tb/tb_vfat_long_name_assembler.sv
